@@ rtl/core/cswft_pkg.sv @@
// Shared constants, register indexes and fixed-point helpers for the cycloid
// swing-foot trajectory block. No dependencies; imported by every module of the block.
`default_nettype none

package cswft_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SWING_TIME = 2'd1;

    // Register widths and reset values
    localparam int HEIGHT_W = 13;
    localparam int INV_T_W  = 16;
    localparam logic [HEIGHT_W-1:0] SWING_HEIGHT_RST   = 13'd655;
    localparam logic [INV_T_W-1:0]  INV_SWING_TIME_RST = 16'd569;

    // Field widths
    localparam int PHASE_W = 16;
    localparam int POS_W   = 16;
    localparam int VEL_W   = 18;
    localparam int SIN_W   = 17;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 104;

    // Default sine table resolution, entries per turn = 2^SINE_TABLE_BITS
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Fixed-point constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [19:0] INV_PI_Q20 = 20'sd333772;
    localparam logic signed [15:0] PI_Q13     = 16'sd25736;

    // Divide by 2^n, rounding to nearest with halves away from zero.
    // Only ever called with a constant shift.
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                  input int unsigned n);
        logic signed [63:0] half;
        logic signed [63:0] adj;
        half = 64'sd1 <<< (n - 1);
        adj  = (v < 0) ? 64'sd1 : 64'sd0;
        return (v + half - adj) >>> n;
    endfunction

    // Clamp to the signed 16 bit position range.
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Clamp to the signed 18 bit velocity range.
    function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
        if (v > 64'sd131071) begin
            return 18'sh1FFFF;
        end else if (v < -64'sd131072) begin
            return 18'sh20000;
        end
        return 18'(v);
    endfunction

    // Magnitude of sin(pi/2 * a / 2^(tbits-2)) in Q15, by a Q30 Taylor series
    // with truncating products. Evaluated at elaboration to fill the table.
    function automatic logic [15:0] quarter_sine(input int unsigned a,
                                                 input int unsigned tbits);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          res;
        int              i;
        x    = (longint'(a) * HALF_PI_Q30) >> (tbits - 2);
        term = x;
        sum  = longint'(x);
        for (i = 1; i <= 6; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            // Series denominators (2i)(2i+1) for the odd powers of x
            case (i)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((i % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        res = (sum + 64'sd16384) >>> 15;
        if (res > 32768) begin
            res = 32768;
        end
        return 16'(res);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cycloid_swing_foot_trajectory_top.sv @@
// Top level of the cycloid swing-foot trajectory block: stream ports, configuration
// registers and the six-stage arithmetic pipeline. Depends on cswft_pkg and cswft_sine_lut.
`default_nettype none

// One leg sample enters per clock unless the pipeline is full and the output stalled, and
// its result leaves through the six register stages of the multiplier pipeline, each of
// which advances whenever the stage after it is empty or moving. Bubbles are squeezed out
// under back-pressure, so a stalled output does not block intake until the pipeline is
// full. In stance the start position passes through with zero velocity. In swing the
// sine and cosine come from a quarter-wave table of 2^(SINE_TABLE_BITS-2)+1 entries built
// at elaboration. Configuration should only be written while no beat is in flight.
module cycloid_swing_foot_trajectory_top
    import cswft_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration write port
    input  wire                    i_cfg_wen,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input stream
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // phase[15:0], start_x[31:16], start_y[47:32], start_z[63:48],
    // end_x[79:64], end_y[95:80]
    input  wire [S_TDATA_W-1:0]    s_axis_tdata,
    // in_contact[0]
    input  wire [0:0]              s_axis_tuser,
    // Output stream
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], vel_x[65:48], vel_y[83:66],
    // vel_z[101:84], zero[103:102]
    output logic [M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NSTG = 6;

    // Configuration registers
    logic [HEIGHT_W-1:0] r_swing_height;
    logic [INV_T_W-1:0]  r_inv_swing_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swing_height   <= SWING_HEIGHT_RST;
            r_inv_swing_time <= INV_SWING_TIME_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_SWING_HEIGHT:   r_swing_height   <= i_cfg_wdata[HEIGHT_W-1:0];
                REG_INV_SWING_TIME: r_inv_swing_time <= i_cfg_wdata[INV_T_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and per-stage advance; a stage moves when it is empty or its
    // successor moves.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;

    always_comb begin
        w_en[NSTG] = ~r_vld[NSTG] | m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[1];
    assign m_axis_tvalid = r_vld[NSTG];

    // Input field unpacking
    logic [PHASE_W-1:0]      w_phase;
    logic signed [POS_W-1:0] w_sx, w_sy, w_sz, w_ex, w_ey;

    assign w_phase = s_axis_tdata[15:0];
    assign w_sx    = s_axis_tdata[31:16];
    assign w_sy    = s_axis_tdata[47:32];
    assign w_sz    = s_axis_tdata[63:48];
    assign w_ex    = s_axis_tdata[79:64];
    assign w_ey    = s_axis_tdata[95:80];

    // Stage 1: capture the beat and form the x/y spans.
    logic                    r1_contact;
    logic [PHASE_W-1:0]      r1_phase;
    logic signed [POS_W-1:0] r1_sx, r1_sy, r1_sz;
    logic signed [POS_W:0]   r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_contact <= s_axis_tuser[0];
            r1_phase   <= w_phase;
            r1_sx      <= w_sx;
            r1_sy      <= w_sy;
            r1_sz      <= w_sz;
            r1_dx      <= 17'(w_ex) - 17'(w_sx);
            r1_dy      <= 17'(w_ey) - 17'(w_sy);
        end
    end

    // Stage 2: table lookup, plus the product of height and swing rate.
    logic signed [SIN_W-1:0] r2_sin;
    logic [SIN_W-1:0]        r2_omc;
    logic                    r2_contact;
    logic [PHASE_W-1:0]      r2_phase;
    logic signed [POS_W-1:0] r2_sx, r2_sy, r2_sz;
    logic signed [POS_W:0]   r2_dx, r2_dy;
    logic [28:0]             r2_hinv;

    cswft_sine_lut #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_lut (
        .i_clk   (i_clk),
        .i_en    (w_en[2]),
        .i_phase (r1_phase),
        .o_sin   (r2_sin),
        .o_omc   (r2_omc)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_contact <= r1_contact;
            r2_phase   <= r1_phase;
            r2_sx      <= r1_sx;
            r2_sy      <= r1_sy;
            r2_sz      <= r1_sz;
            r2_dx      <= r1_dx;
            r2_dy      <= r1_dy;
            r2_hinv    <= r_swing_height * r_inv_swing_time;
        end
    end

    // Stage 3: first products against the table values.
    logic                    r3_contact;
    logic [PHASE_W-1:0]      r3_phase;
    logic signed [POS_W-1:0] r3_sx, r3_sy, r3_sz;
    logic signed [POS_W:0]   r3_dx, r3_dy;
    logic [28:0]             r3_hinv;
    logic signed [36:0]      r3_p_snpi;
    logic [29:0]             r3_p_hz;
    logic signed [34:0]      r3_p_dxo, r3_p_dyo;
    logic signed [32:0]      r3_p_snq;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_contact <= r2_contact;
            r3_phase   <= r2_phase;
            r3_sx      <= r2_sx;
            r3_sy      <= r2_sy;
            r3_sz      <= r2_sz;
            r3_dx      <= r2_dx;
            r3_dy      <= r2_dy;
            r3_hinv    <= r2_hinv;
            r3_p_snpi  <= r2_sin * INV_PI_Q20;
            r3_p_hz    <= r_swing_height * r2_omc;
            r3_p_dxo   <= r2_dx * signed'({1'b0, r2_omc});
            r3_p_dyo   <= r2_dy * signed'({1'b0, r2_omc});
            r3_p_snq   <= r2_sin * PI_Q13;
        end
    end

    // Stage 4: path fraction, final z position and the velocity products.
    logic                    r4_contact;
    logic signed [POS_W-1:0] r4_sx, r4_sy;
    logic signed [POS_W:0]   r4_dx, r4_dy;
    logic signed [17:0]      r4_frac;
    logic signed [POS_W-1:0] r4_pos_z;
    logic signed [51:0]      r4_p_vx, r4_p_vy;
    logic signed [62:0]      r4_p_vz;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_contact <= r3_contact;
            r4_sx      <= r3_sx;
            r4_sy      <= r3_sy;
            r4_dx      <= r3_dx;
            r4_dy      <= r3_dy;
            r4_frac    <= 18'(64'(signed'({1'b0, r3_phase}))
                              - rnd_sh(64'(r3_p_snpi), 20));
            r4_pos_z   <= r3_contact ? r3_sz
                        : sat16(64'(r3_sz) + rnd_sh(64'(signed'({1'b0, r3_p_hz})), 16));
            r4_p_vx    <= r3_p_dxo * signed'({1'b0, r_inv_swing_time});
            r4_p_vy    <= r3_p_dyo * signed'({1'b0, r_inv_swing_time});
            r4_p_vz    <= signed'({1'b0, r3_hinv}) * r3_p_snq;
        end
    end

    // Stage 5: x/y position products; velocities rounded and clamped.
    logic                    r5_contact;
    logic signed [POS_W-1:0] r5_sx, r5_sy;
    logic signed [34:0]      r5_p_px, r5_p_py;
    logic signed [POS_W-1:0] r5_pos_z;
    logic signed [VEL_W-1:0] r5_vel_x, r5_vel_y, r5_vel_z;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_contact <= r4_contact;
            r5_sx      <= r4_sx;
            r5_sy      <= r4_sy;
            r5_p_px    <= r4_dx * r4_frac;
            r5_p_py    <= r4_dy * r4_frac;
            r5_pos_z   <= r4_pos_z;
            r5_vel_x   <= r4_contact ? '0 : sat18(rnd_sh(64'(r4_p_vx), 23));
            r5_vel_y   <= r4_contact ? '0 : sat18(rnd_sh(64'(r4_p_vy), 23));
            r5_vel_z   <= r4_contact ? '0 : sat18(rnd_sh(64'(r4_p_vz), 36));
        end
    end

    // Stage 6: output register with the final x/y positions.
    logic                    r6_contact;
    logic signed [POS_W-1:0] r6_pos_x, r6_pos_y, r6_pos_z;
    logic signed [VEL_W-1:0] r6_vel_x, r6_vel_y, r6_vel_z;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_contact <= r5_contact;
            r6_pos_x   <= r5_contact ? r5_sx
                        : sat16(64'(r5_sx) + rnd_sh(64'(r5_p_px), 16));
            r6_pos_y   <= r5_contact ? r5_sy
                        : sat16(64'(r5_sy) + rnd_sh(64'(r5_p_py), 16));
            r6_pos_z   <= r5_pos_z;
            r6_vel_x   <= r5_vel_x;
            r6_vel_y   <= r5_vel_y;
            r6_vel_z   <= r5_vel_z;
        end
    end

    assign m_axis_tdata = {2'b00, r6_vel_z, r6_vel_y, r6_vel_x,
                           r6_pos_z, r6_pos_y, r6_pos_x};

    // A stance beat leaves with all three velocities zero.
    a_stance_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r6_contact) |->
            (r6_vel_x == '0 && r6_vel_y == '0 && r6_vel_z == '0))
        else $error("stance beat with non-zero velocity");

    // Intake only stops when the whole pipeline is full and the output is held.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&r_vld)))
        else $error("input stalled while the pipeline has room");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ rtl/core/cswft_sine_lut.sv @@
// Sine and one-minus-cosine lookup from the swing phase, with a registered output.
// Depends on cswft_pkg; the quarter-wave table is built at elaboration.
`default_nettype none

module cswft_sine_lut
    import cswft_pkg::*;
#(
    parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire [PHASE_W-1:0]         i_phase,
    output logic signed [SIN_W-1:0]   o_sin,
    output logic [SIN_W-1:0]          o_omc
);

    localparam int QN = 1 << (TABLE_BITS - 2);
    localparam int SH = PHASE_W - TABLE_BITS;

    typedef logic [15:0] t_qtab [QN+1];

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int a = 0; a <= QN; a++) begin
            tab[a] = quarter_sine(a, TABLE_BITS);
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    // Fold a full-turn index onto the quarter table and restore the sign.
    function automatic logic signed [SIN_W-1:0] lookup(input logic [TABLE_BITS-1:0] k);
        logic [1:0]            q;
        logic [TABLE_BITS-3:0] r;
        logic [TABLE_BITS-2:0] a;
        logic [SIN_W-1:0]      mag;
        q   = k[TABLE_BITS-1 -: 2];
        r   = k[TABLE_BITS-3:0];
        a   = q[0] ? ((TABLE_BITS-1)'(QN) - {1'b0, r}) : {1'b0, r};
        mag = {1'b0, QTAB[a]};
        return q[1] ? -signed'(mag) : signed'(mag);
    endfunction

    logic [PHASE_W-1:0]           w_rnd_phase;
    logic [TABLE_BITS-1:0]        w_k_sin;
    logic [TABLE_BITS-1:0]        w_k_cos;
    logic signed [SIN_W-1:0]      w_cos;
    logic signed [SIN_W:0]        w_omc_full;

    // Round the phase to the nearest table step; wraps to zero near a full turn.
    assign w_rnd_phase = i_phase + PHASE_W'(1 << (SH - 1));
    assign w_k_sin     = w_rnd_phase[PHASE_W-1:SH];
    assign w_k_cos     = w_k_sin + TABLE_BITS'(QN);
    assign w_cos       = lookup(w_k_cos);
    assign w_omc_full  = 18'sd32768 - 18'(w_cos);

    // Registered table read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= lookup(w_k_sin);
            o_omc <= w_omc_full[SIN_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ tb/cycloid_swing_foot_trajectory_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for cycloid_swing_foot_trajectory_top: streams leg samples,
// writes the configuration registers between phases and checks every foot command beat.
// Depends on cswft_pkg and the block's RTL only; reads no files.

module cycloid_swing_foot_trajectory_top_tb;
    import cswft_pkg::*;

    localparam int              CLK_PERIOD         = 10;
    localparam int              RESET_CYCLES       = 10;
    localparam int              SETTLE_CYCLES      = 8;
    localparam int              WATCHDOG_LIMIT     = 2000;
    localparam int              LONG_HOLD_CYCLES   = 300;
    localparam int              BACKLOG_BEATS      = 60;
    localparam int              N_SETTINGS         = 5;
    localparam int              RANDOM_PER_SETTING = 230;
    localparam int              BURST_LEN          = 40;

    // Sine table geometry and fixed-point constants for the trajectory predictor
    localparam int              TABLE_BITS    = SINE_TABLE_BITS_DEF;
    localparam longint unsigned TABLE_SIZE    = 64'd1 << TABLE_BITS;
    localparam longint unsigned QUARTER_SIZE  = TABLE_SIZE >> 2;
    localparam longint unsigned HALF_PI_Q30_U = 64'd1686629713;
    localparam longint          RECIP_PI_Q20  = 333772;
    localparam longint          PI_Q13_L      = 25736;

    // Indexes past the register map, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    typedef struct {
        logic               in_contact;
        logic [15:0]        phase;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } leg_sample_t;

    typedef struct {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
    } foot_cmd_t;

    // Predicts the foot command for each accepted leg sample and checks output beats
    // against the oldest outstanding prediction.
    class foot_cmd_scoreboard;
        logic [HEIGHT_W-1:0] lift_height;
        logic [INV_T_W-1:0]  inv_swing;
        foot_cmd_t           pending_cmds[$];
        int unsigned         fail_count;

        function new();
            lift_height = SWING_HEIGHT_RST;
            inv_swing   = INV_SWING_TIME_RST;
            fail_count  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SWING_HEIGHT) begin
                lift_height = data[HEIGHT_W-1:0];
            end else if (idx == REG_INV_SWING_TIME) begin
                inv_swing = data;
            end
        endfunction

        function int unsigned outstanding();
            return pending_cmds.size();
        endfunction

        // Divide by 2^n, rounding to nearest with halves away from zero.
        function longint round_half_away(longint v, int unsigned n);
            longint half;
            half = longint'(1) <<< (n - 1);
            if (v >= 0) begin
                return (v + half) >>> n;
            end
            return -((half - v) >>> n);
        endfunction

        function longint clamp_signed(longint v, int unsigned w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -(longint'(1) <<< (w - 1));
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        // Table entry k in Q15: quarter-wave folding, then a Q30 Taylor series with
        // truncating products, rounded and capped at one.
        function longint table_sine(longint unsigned k);
            longint unsigned quad;
            longint unsigned a;
            longint unsigned x;
            longint unsigned term;
            longint unsigned divisor;
            longint          sum;
            longint          mag;
            int              i;
            k    = k & (TABLE_SIZE - 1);
            quad = k >> (TABLE_BITS - 2);
            a    = k & (QUARTER_SIZE - 1);
            if (quad[0]) begin
                a = QUARTER_SIZE - a;
            end
            x    = (a * HALF_PI_Q30_U) >> (TABLE_BITS - 2);
            term = x;
            sum  = longint'(x);
            for (i = 1; i <= 6; i++) begin
                term    = (term * x) >> 30;
                term    = (term * x) >> 30;
                divisor = (2 * i) * (2 * i + 1);
                term    = term / divisor;
                if ((i % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            mag = (sum + 16384) >>> 15;
            if (mag > 32768) begin
                mag = 32768;
            end
            return quad[1] ? -mag : mag;
        endfunction

        function void note_leg(leg_sample_t s);
            foot_cmd_t cmd;
            longint    ph;
            longint    k;
            longint    sn;
            longint    cs;
            longint    omc;
            longint    frac;
            longint    sx;
            longint    sy;
            longint    sz;
            longint    dx;
            longint    dy;
            longint    h;
            longint    inv;
            sx = s.start_x;
            sy = s.start_y;
            sz = s.start_z;
            if (s.in_contact) begin
                // Stance: the foot holds its start position
                cmd.pos_x = s.start_x;
                cmd.pos_y = s.start_y;
                cmd.pos_z = s.start_z;
                cmd.vel_x = '0;
                cmd.vel_y = '0;
                cmd.vel_z = '0;
            end else begin
                ph   = s.phase;
                k    = (ph + (longint'(1) <<< (15 - TABLE_BITS))) >>> (16 - TABLE_BITS);
                sn   = table_sine(k);
                cs   = table_sine(k + QUARTER_SIZE);
                omc  = 32768 - cs;
                frac = ph - round_half_away(sn * RECIP_PI_Q20, 20);
                dx   = longint'(s.end_x) - sx;
                dy   = longint'(s.end_y) - sy;
                h    = lift_height;
                inv  = inv_swing;
                cmd.pos_x = 16'(clamp_signed(sx + round_half_away(dx * frac, 16), POS_W));
                cmd.pos_y = 16'(clamp_signed(sy + round_half_away(dy * frac, 16), POS_W));
                cmd.pos_z = 16'(clamp_signed(sz + round_half_away(h * omc, 16), POS_W));
                cmd.vel_x = 18'(clamp_signed(round_half_away(dx * omc * inv, 23), VEL_W));
                cmd.vel_y = 18'(clamp_signed(round_half_away(dy * omc * inv, 23), VEL_W));
                cmd.vel_z = 18'(clamp_signed(
                    round_half_away(h * sn * PI_Q13_L * inv, 36), VEL_W));
            end
            pending_cmds.push_back(cmd);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            foot_cmd_t want;
            if (pending_cmds.size() == 0) begin
                $error("foot command beat %h arrived with no leg sample outstanding", beat);
                fail_count++;
                return;
            end
            want = pending_cmds.pop_front();
            compare_field("pos_x", want.pos_x, $signed(beat[15:0]));
            compare_field("pos_y", want.pos_y, $signed(beat[31:16]));
            compare_field("pos_z", want.pos_z, $signed(beat[47:32]));
            compare_field("vel_x", want.vel_x, $signed(beat[65:48]));
            compare_field("vel_y", want.vel_y, $signed(beat[83:66]));
            compare_field("vel_z", want.vel_z, $signed(beat[101:84]));
            compare_field("pad", 0, beat[103:102]);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    foot_cmd_scoreboard board;
    logic               hold_off_req = 1'b0;
    logic               hold_active  = 1'b0;
    int unsigned        idle_cycles  = 0;

    cycloid_swing_foot_trajectory_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic leg_sample_t make_leg(logic contact, logic [15:0] phase,
                                             int sx, int sy, int sz, int ex, int ey);
        leg_sample_t s;
        s.in_contact = contact;
        s.phase      = phase;
        s.start_x    = 16'(sx);
        s.start_y    = 16'(sy);
        s.start_z    = 16'(sz);
        s.end_x      = 16'(ex);
        s.end_y      = 16'(ey);
        return s;
    endfunction

    // Mostly swing samples; phases are spread over the turn with extra weight at the
    // ends, and a third of the steps are short strides like a real gait.
    function automatic leg_sample_t random_leg();
        leg_sample_t s;
        int unsigned pick;
        s.in_contact = ($urandom_range(0, 99) < 15);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            s.phase = 16'($urandom_range(0, 127));
        end else if (pick == 1) begin
            s.phase = 16'(65535 - $urandom_range(0, 127));
        end else begin
            s.phase = 16'($urandom);
        end
        s.start_x = 16'($urandom);
        s.start_y = 16'($urandom);
        s.start_z = 16'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            s.end_x = 16'(s.start_x + $urandom_range(0, 2047) - 1024);
            s.end_y = 16'(s.start_y + $urandom_range(0, 2047) - 1024);
        end else begin
            s.end_x = 16'($urandom);
            s.end_y = 16'($urandom);
        end
        return s;
    endfunction

    // Offer one leg sample and hold it until the block takes the beat.
    task automatic send_leg(input leg_sample_t s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.end_y, s.end_x, s.start_z, s.start_y, s.start_x, s.phase};
        s_axis_tuser  <= s.in_contact;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_leg(s);
    endtask

    task automatic sender_gap(input int unsigned n);
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every predicted command, then let the pipeline settle.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Output side pacing: random ready runs and stalls, plus one long hold-off on request.
    initial begin : sink_pacing
        int unsigned run;
        int unsigned r;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_active  = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    m_axis_tready <= 1'b0;
                    run = 1 + pick_gap();
                end else begin
                    m_axis_tready <= 1'b1;
                    r = $urandom_range(0, 9);
                    if (r < 6) begin
                        run = $urandom_range(1, 8);
                    end else if (r < 9) begin
                        run = $urandom_range(9, 40);
                    end else begin
                        run = $urandom_range(60, 150);
                    end
                end
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // Check every foot command beat the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
        end
    end

    // Give up if neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        leg_sample_t       directed[$];
        logic [HEIGHT_W-1:0] heights[N_SETTINGS];
        logic [INV_T_W-1:0]  invs[N_SETTINGS];
        int unsigned       n;
        int unsigned       s;

        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        board = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Writes past the register map must leave the reset values in place
        write_reg(REG_UNMAPPED_2, 16'($urandom));
        write_reg(REG_UNMAPPED_3, 16'($urandom));

        // Directed samples under the reset configuration
        directed.push_back(make_leg(1'b1, 16'h1234, 32767, -32768, -1, 0, 0));
        directed.push_back(make_leg(1'b1, 16'hFFFF, -32768, 32767, 32767, -32768, 32767));
        directed.push_back(make_leg(1'b0, 16'h0000, 100, -200, 50, 5000, -6000));
        directed.push_back(make_leg(1'b0, 16'hFFFF, 100, -200, 50, 5000, -6000));
        directed.push_back(make_leg(1'b0, 16'h2000, -1000, 1000, 0, 3000, -3000));
        directed.push_back(make_leg(1'b0, 16'h4000, -1000, 1000, 0, 3000, -3000));
        directed.push_back(make_leg(1'b0, 16'h6000, 2000, 2000, -500, -2000, 6000));
        directed.push_back(make_leg(1'b0, 16'h8000, -32768, 32767, 0, 32767, -32768));
        directed.push_back(make_leg(1'b0, 16'hA000, 2000, 2000, -500, -2000, 6000));
        directed.push_back(make_leg(1'b0, 16'hC000, -32768, 32767, 0, 32767, -32768));
        directed.push_back(make_leg(1'b0, 16'hE000, 32767, -32768, 0, -32768, 32767));
        // Either side of the table index rounding step
        directed.push_back(make_leg(1'b0, 16'd31, 0, 0, 0, 20000, -20000));
        directed.push_back(make_leg(1'b0, 16'd32, 0, 0, 0, 20000, -20000));
        // Position overshoot just after lift-off and just before touchdown
        directed.push_back(make_leg(1'b0, 16'd40, -32768, 32767, 0, 32767, -32768));
        directed.push_back(make_leg(1'b0, 16'd65500, -32768, 32767, 0, 32767, -32768));
        // Height pushes z past the top of its range, and the lowest z
        directed.push_back(make_leg(1'b0, 16'h8000, 0, 0, 32767, 0, 0));
        directed.push_back(make_leg(1'b0, 16'h0000, 0, 0, -32768, 0, 0));
        // No horizontal travel, then a step of one in x and y
        directed.push_back(make_leg(1'b0, 16'h5555, 1234, -4321, 777, 1234, -4321));
        directed.push_back(make_leg(1'b0, 16'hAAAA, -1, -1, -1, 0, 0));
        foreach (directed[i]) begin
            send_leg(directed[i]);
        end
        drain_and_settle();

        // Back-pressure: the output holds off while samples keep coming
        hold_off_req = 1'b1;
        wait (hold_active);
        @(posedge i_clk);
        repeat (BACKLOG_BEATS) begin
            send_leg(random_leg());
        end
        drain_and_settle();

        // Register settings, extremes first, each followed by a random stream
        heights[0] = 13'd8191;
        invs[0]    = 16'd65535;
        heights[1] = 13'd0;
        invs[1]    = 16'd0;
        heights[2] = 13'($urandom);
        invs[2]    = 16'd1;
        heights[3] = 13'($urandom);
        invs[3]    = 16'($urandom_range(1, 65535));
        heights[4] = 13'($urandom);
        invs[4]    = 16'($urandom);
        for (s = 0; s < N_SETTINGS; s++) begin
            write_reg(REG_SWING_HEIGHT, {3'($urandom), heights[s]});
            write_reg(REG_INV_SWING_TIME, invs[s]);
            for (n = 0; n < RANDOM_PER_SETTING; n++) begin
                send_leg(random_leg());
                sender_gap((n < BURST_LEN) ? 0 : pick_gap());
            end
            drain_and_settle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.fail_count == 0 && board.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
